// ===== hdl/iopb_pkg.sv =====
// Package for the I/O port permission bitmap.
// Request opcodes, fixed field widths and default sizes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iopb_pkg;

   // Request opcodes
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } iopb_op_type;

   // Fixed field widths
   localparam int PORT_W  = 16;
   localparam int COUNT_W = 17;

   // Default sizes
   localparam int DEF_PORT_COUNT = 65536;
   localparam int DEF_WORD_BITS  = 64;
   localparam int DEF_REV_WIDTH  = 32;

endpackage

`default_nettype wire

// ===== hdl/iopb_bitmap_ram.sv =====
// Bitmap word store: one write port, one read port, registered read data.
// Standalone; sized by the top level.
`timescale 1ns / 1ps
`default_nettype none

module iopb_bitmap_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/io_port_permission_bitmap.sv =====
// Top level of the I/O port permission bitmap: request decode, word
// read-modify-write, whole-space sweeps. Uses iopb_pkg and iopb_bitmap_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+--------------------------------------
//  req_*     | in        | req_valid/req_stall | opcode, port, whole, full_rights
//  rsp_*     | out       | rsp_valid/rsp_stall | status, found, whole_range, phys_base,
//            |           |                     | flush_request, enabled_count,
//            |           |                     | revision_now, whole_mode_now
//
//  Single-port request: transfer and word read, then modify and write back.
//  NUM_WORDS-word sweep, one per cycle: zero-count whole insert, whole-mode full delete.
//  After reset a clearing pass fills every word with ones; req_stall stays high meanwhile.
//  One request in flight; a new one is taken while the previous result waits in the output
//  register; rsp_stall holds the engine only when a second result is ready to load.

module io_port_permission_bitmap
   import iopb_pkg::*;
#(
   parameter int PORT_COUNT = DEF_PORT_COUNT,
   parameter int WORD_BITS  = DEF_WORD_BITS,
   parameter int REV_WIDTH  = DEF_REV_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [PORT_W-1:0]    req_port,
   input  wire logic                 req_whole,
   input  wire logic                 req_full_rights,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_status,
   output logic                      rsp_found,
   output logic                      rsp_whole_range,
   output logic [PORT_W-1:0]         rsp_phys_base,
   output logic                      rsp_flush_request,
   output logic [COUNT_W-1:0]        rsp_enabled_count,
   output logic [REV_WIDTH-1:0]      rsp_revision_now,
   output logic                      rsp_whole_mode_now
);

   // ---------------------------------------------------------------------------
   // Geometry
   // ---------------------------------------------------------------------------
   localparam int NUM_WORDS = (PORT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int CNT_W     = $clog2(WORD_BITS + 1);
   localparam int LAST_BITS = PORT_COUNT - (NUM_WORDS - 1) * WORD_BITS;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

   // Enable-all fill: bits past the end of the port space stay disabled.
   localparam logic [WORD_BITS-1:0] LAST_FILL = {WORD_BITS{1'b1}} << LAST_BITS;

   // port / WORD_BITS by reciprocal multiply; exact for every 16-bit port.
   localparam int DIV_SHIFT = PORT_W + BIT_W;
   localparam int MUL_W     = PORT_W + 1;
   localparam int PROD_W    = PORT_W + MUL_W;
   localparam int Q_W       = PROD_W - DIV_SHIFT;
   localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;

   localparam int REV_XW = REV_WIDTH + 1;
   localparam logic [REV_WIDTH-1:0] REV_MAX = {REV_WIDTH{1'b1}};

   // Revision advance by n single enables; zero is skipped on wrap.
   function automatic logic [REV_WIDTH-1:0] rev_add(input logic [REV_WIDTH-1:0] r,
                                                     input logic [CNT_W-1:0] n);
      logic [REV_WIDTH:0] s;
      s = {1'b0, r} + REV_XW'(n);
      if (r == '0) begin
         rev_add = REV_WIDTH'(n);
      end else if (s > {1'b0, REV_MAX}) begin
         rev_add = REV_WIDTH'(s - {1'b0, REV_MAX});
      end else begin
         rev_add = s[REV_WIDTH-1:0];
      end
   endfunction

   typedef enum logic [2:0] {
      ST_CLEAR,   // post-reset fill of all words with ones
      ST_IDLE,    // waiting for a request
      ST_EXEC,    // word read data valid: decide, write back, load result
      ST_SWEEP,   // whole-space enable or disable, one word per cycle
      ST_DONE     // sweep finished, load result
   } state_type;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   sweep_del_ff, sweep_del_in;
   logic [COUNT_W-1:0]     total_ff, total_in;
   logic [REV_WIDTH-1:0]   rev_ff, rev_in;
   logic                   wmode_ff, wmode_in;

   logic [1:0]             op_ff, op_in;
   logic [PORT_W-1:0]      port_ff, port_in;
   logic [Q_W-1:0]         q_ff, q_in;
   logic                   whole_ff, whole_in;
   logic                   full_ff, full_in;
   logic                   in_rng_ff, in_rng_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_wrange_ff, rsp_wrange_in;
   logic [PORT_W-1:0]      rsp_phys_ff, rsp_phys_in;
   logic                   rsp_flush_ff, rsp_flush_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [REV_WIDTH-1:0]   rsp_rev_ff, rsp_rev_in;
   logic                   rsp_wmode_ff, rsp_wmode_in;

   // ---------------------------------------------------------------------------
   // Bitmap store
   // ---------------------------------------------------------------------------
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [WORD_BITS-1:0]   ram_rd_data;

   logic [PROD_W-1:0]      div_prod;
   logic [BIT_W-1:0]       bit_off;
   logic                   bit_dis;
   logic                   req_xfer;
   logic                   rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign ram_rd_en = req_xfer;

   assign div_prod = PROD_W'(req_port) * PROD_W'(MUL_W'(DIV_MUL));
   assign bit_off  = BIT_W'(port_ff - PORT_W'(q_ff * WORD_BITS));
   assign bit_dis  = ram_rd_data[bit_off];

   iopb_bitmap_ram #(
      .DEPTH  (NUM_WORDS),
      .WIDTH  (WORD_BITS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (div_prod[DIV_SHIFT +: ADDR_W]),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      sweep_del_in = sweep_del_ff;
      total_in     = total_ff;
      rev_in       = rev_ff;
      wmode_in     = wmode_ff;

      op_in        = op_ff;
      port_in      = port_ff;
      q_in         = q_ff;
      whole_in     = whole_ff;
      full_in      = full_ff;
      in_rng_in    = in_rng_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_wrange_in = rsp_wrange_ff;
      rsp_phys_in   = rsp_phys_ff;
      rsp_flush_in  = rsp_flush_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rev_in    = rsp_rev_ff;
      rsp_wmode_in  = rsp_wmode_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = {WORD_BITS{1'b1}};

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_xfer) begin
               op_in     = req_opcode;
               port_in   = req_port;
               q_in      = div_prod[DIV_SHIFT +: Q_W];
               whole_in  = req_whole;
               full_in   = req_full_rights;
               in_rng_in = {1'b0, req_port} < COUNT_W'(PORT_COUNT);
               state_in  = ST_EXEC;
            end
         end

         ST_EXEC: begin
            ram_wr_addr = q_ff[ADDR_W-1:0];
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_found_in  = 1'b0;
               rsp_wrange_in = 1'b0;
               rsp_phys_in   = '0;
               rsp_flush_in  = 1'b0;
               state_in      = ST_IDLE;
               unique case (op_ff)
                  OP_LOOKUP: begin
                     if (wmode_ff) begin
                        rsp_found_in  = 1'b1;
                        rsp_wrange_in = 1'b1;
                     end else if (in_rng_ff && !bit_dis) begin
                        rsp_found_in = 1'b1;
                        rsp_phys_in  = port_ff;
                     end else if (total_ff == '0) begin
                        rsp_wrange_in = 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (whole_ff && wmode_ff) begin
                        rsp_status_in = 1'b1;
                     end else if (whole_ff && total_ff == '0) begin
                        rsp_valid_in = 1'b0;
                        sweep_del_in = 1'b0;
                        addr_in      = '0;
                        state_in     = ST_SWEEP;
                     end else if (in_rng_ff) begin
                        if (bit_dis) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_data = ram_rd_data & ~(WORD_BITS'(1) << bit_off);
                           total_in    = total_ff + 1'b1;
                           rev_in      = rev_add(rev_ff, CNT_W'(1));
                        end else begin
                           rsp_status_in = 1'b1;
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (full_ff) begin
                        rsp_flush_in = 1'b1;
                        if (wmode_ff) begin
                           rsp_valid_in = 1'b0;
                           sweep_del_in = 1'b1;
                           addr_in      = '0;
                           state_in     = ST_SWEEP;
                        end else if (in_rng_ff && !bit_dis) begin
                           ram_wr_en   = 1'b1;
                           ram_wr_data = ram_rd_data | (WORD_BITS'(1) << bit_off);
                           total_in    = total_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = total_in;
               rsp_rev_in   = rev_in;
               rsp_wmode_in = wmode_in;
            end
         end

         ST_SWEEP: begin
            ram_wr_en = 1'b1;
            if (!sweep_del_ff) begin
               ram_wr_data = (addr_ff == LAST_ADDR) ? LAST_FILL : '0;
               rev_in      = rev_add(rev_ff, (addr_ff == LAST_ADDR) ?
                                     CNT_W'(LAST_BITS) : CNT_W'(WORD_BITS));
            end
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               total_in = sweep_del_ff ? '0 : COUNT_W'(PORT_COUNT);
               wmode_in = !sweep_del_ff;
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_found_in  = 1'b0;
               rsp_wrange_in = 1'b0;
               rsp_phys_in   = '0;
               rsp_flush_in  = sweep_del_ff;
               rsp_count_in  = total_ff;
               rsp_rev_in    = rev_ff;
               rsp_wmode_in  = wmode_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // State and registered outputs
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      port_ff       <= port_in;
      q_ff          <= q_in;
      whole_ff      <= whole_in;
      full_ff       <= full_in;
      in_rng_ff     <= in_rng_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_wrange_ff <= rsp_wrange_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_flush_ff  <= rsp_flush_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rev_ff    <= rsp_rev_in;
      rsp_wmode_ff  <= rsp_wmode_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         sweep_del_ff <= 1'b0;
         total_ff     <= '0;
         rev_ff       <= '0;
         wmode_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         sweep_del_ff <= sweep_del_in;
         total_ff     <= total_in;
         rev_ff       <= rev_in;
         wmode_ff     <= wmode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_whole_range    = rsp_wrange_ff;
   assign rsp_phys_base      = rsp_phys_ff;
   assign rsp_flush_request  = rsp_flush_ff;
   assign rsp_enabled_count  = rsp_count_ff;
   assign rsp_revision_now   = rsp_rev_ff;
   assign rsp_whole_mode_now = rsp_wmode_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // A result appears only from the decode cycle or the end of a sweep.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_DONE))
      else $error("result loaded outside decode or sweep end");

   // No bitmap write while waiting for a request.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_wr_en)
      else $error("bitmap written while idle");

   // Whole mode means every port is enabled.
   a_whole_count: assert property (@(posedge clock) disable iff (reset)
      wmode_ff |-> (total_ff == COUNT_W'(PORT_COUNT)))
      else $error("whole mode with partial enable count");

   // Count never exceeds the port space.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COUNT_W'(PORT_COUNT))
      else $error("enable count out of range");

   // Any enabled port implies the revision has left zero.
   a_rev_nonzero: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> (rev_ff != '0))
      else $error("revision zero with ports enabled");

endmodule

`default_nettype wire

// ===== sim/io_port_permission_bitmap_tb.sv =====
// Testbench for io_port_permission_bitmap: a directed table, then random request episodes.
// Results checked against a bitmap predictor or typed answers. Uses iopb_pkg and the RTL.
`timescale 1ns / 1ps

module io_port_permission_bitmap_tb;
   import iopb_pkg::*;

   localparam int N_PORTS = DEF_PORT_COUNT;
   localparam int REV_W   = DEF_REV_WIDTH;
   // Opcode 3 is not decoded by the block; it must answer with all flags clear.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1750;
   // Slowest correct run: ~1.8k requests, each slowed by sender gaps and the longest
   // receiver stall runs, under a hundred whole-space sweeps, and the clearing pass
   // after reset. CYCLE_LIMIT lies well above all of it.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic               status;
      logic               found;
      logic               whole_range;
      logic [PORT_W-1:0]  phys_base;
      logic               flush_request;
      logic [COUNT_W-1:0] enabled_count;
      logic [REV_W-1:0]   revision_now;
      logic               whole_mode_now;
   } bitmap_answer_type;

   typedef struct {
      logic [1:0]        op;
      logic [PORT_W-1:0] port;
      logic              whole;
      logic              full;
      bit                typed;   // 1: use ans below instead of the predictor's answer
      bitmap_answer_type ans;
   } stim_row_type;

   localparam bitmap_answer_type NO_ANS = '0;

   // ---------------------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------------------
   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_opcode;
   logic [PORT_W-1:0]   req_port;
   logic                req_whole;
   logic                req_full_rights;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_status;
   logic                rsp_found;
   logic                rsp_whole_range;
   logic [PORT_W-1:0]   rsp_phys_base;
   logic                rsp_flush_request;
   logic [COUNT_W-1:0]  rsp_enabled_count;
   logic [REV_W-1:0]    rsp_revision_now;
   logic                rsp_whole_mode_now;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   io_port_permission_bitmap DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_port           (req_port),
      .req_whole          (req_whole),
      .req_full_rights    (req_full_rights),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_whole_range    (rsp_whole_range),
      .rsp_phys_base      (rsp_phys_base),
      .rsp_flush_request  (rsp_flush_request),
      .rsp_enabled_count  (rsp_enabled_count),
      .rsp_revision_now   (rsp_revision_now),
      .rsp_whole_mode_now (rsp_whole_mode_now)
   );

   // ---------------------------------------------------------------------------------
   // Predictor: own copy of the bitmap (1 = disabled), count, revision, whole flag
   // ---------------------------------------------------------------------------------
   bit   [N_PORTS-1:0] port_off;
   int                 enabled_total;
   logic [REV_W-1:0]   revision;
   bit                 whole_mode;
   int                 sweeps;

   bitmap_answer_type answers_due [$];   // expected results, oldest first
   logic [PORT_W-1:0] enabled_list [$];  // ports of insert requests, for cleanup deletes

   int errors;
   int sent;
   int checked;
   int cycle_count;
   int burst_left;

   // Enable one port; 0 if newly enabled, 1 if already enabled or out of range.
   // Revision advances per newly enabled port and skips zero on wrap.
   function automatic bit enable_one(int p);
      if (p >= N_PORTS || !port_off[p]) return 1'b1;
      port_off[p] = 1'b0;
      enabled_total++;
      revision = revision + 1'b1;
      if (revision == '0) revision = 1;
      return 1'b0;
   endfunction

   function automatic void disable_one(int p);
      if (p < N_PORTS && !port_off[p]) begin
         port_off[p] = 1'b1;
         if (enabled_total > 0) enabled_total--;
      end
   endfunction

   // Applies one accepted request to the predictor state and returns its result.
   function automatic bitmap_answer_type predict_bitmap(logic [1:0] op,
                                                        logic [PORT_W-1:0] port,
                                                        logic whole, logic full);
      bitmap_answer_type a;
      int pnum;
      a = '0;
      pnum = 32'(port);
      case (op)
         OP_LOOKUP: begin
            if (whole_mode) begin
               a.found = 1'b1;
               a.whole_range = 1'b1;
            end else if (pnum < N_PORTS && !port_off[pnum]) begin
               a.found = 1'b1;
               a.phys_base = port;
            end else if (enabled_total == 0) begin
               a.whole_range = 1'b1;
            end
         end
         OP_INSERT: begin
            if (whole && whole_mode) begin
               a.status = 1'b1;
            end else if (whole && enabled_total == 0) begin
               for (int p = 0; p < N_PORTS; p++) void'(enable_one(p));
               whole_mode = 1'b1;
               sweeps++;
            end else if (pnum < N_PORTS) begin
               // whole insert with ports partly enabled lands here too
               a.status = enable_one(pnum);
            end
         end
         OP_DELETE: begin
            if (full) begin
               if (whole_mode) begin
                  // whole mode: sweep regardless of the whole bit
                  for (int p = 0; p < N_PORTS; p++) disable_one(p);
                  whole_mode = 1'b0;
                  sweeps++;
               end else begin
                  disable_one(pnum);
               end
               a.flush_request = 1'b1;
            end
         end
         default: ;
      endcase
      a.enabled_count  = COUNT_W'(enabled_total);
      a.revision_now   = revision;
      a.whole_mode_now = whole_mode;
      return a;
   endfunction

   // ---------------------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------------------
   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      bitmap_answer_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
         end else begin
            want = answers_due.pop_front();
            checked++;
            check_field("status", want.status, rsp_status);
            check_field("found", want.found, rsp_found);
            check_field("whole_range", want.whole_range, rsp_whole_range);
            check_field("phys_base", want.phys_base, rsp_phys_base);
            check_field("flush_request", want.flush_request, rsp_flush_request);
            check_field("enabled_count", want.enabled_count, rsp_enabled_count);
            check_field("revision_now", want.revision_now, rsp_revision_now);
            check_field("whole_mode_now", want.whole_mode_now, rsp_whole_mode_now);
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, answers_due.size());
         $display("io_port_permission_bitmap_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: rsp_stall follows its own pattern, switching mode every so often
   // ---------------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int mode;
      int run;
      int k;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         run = $urandom_range(20, 200);
         for (k = 0; k < run; k++) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;                            // free running
               1: rsp_stall <= ($urandom_range(0, 3) == 0);     // light
               2: rsp_stall <= ($urandom_range(0, 3) != 0);     // heavy
               default: rsp_stall <= ((k % 16) < 10);           // long stall runs
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------

   // Holds valid and payload until the transfer, then records the expected result.
   task automatic send_request(logic [1:0] op, logic [PORT_W-1:0] port, logic whole,
                               logic full, bit typed, bitmap_answer_type typed_ans);
      bitmap_answer_type predicted;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_port        <= port;
      req_whole       <= whole;
      req_full_rights <= full;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_bitmap(op, port, whole, full);
      answers_due.push_back(typed ? typed_ans : predicted);
      sent++;
   endtask

   // Bursts of random length; a random gap (sometimes none) opens each burst.
   task automatic issue(logic [1:0] op, logic [PORT_W-1:0] port, logic whole, logic full,
                        bit typed = 1'b0, bitmap_answer_type typed_ans = NO_ANS);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_request(op, port, whole, full, typed, typed_ans);
   endtask

   // Pause the sender until every outstanding result has been taken.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // One episode: a small pool of ports gets lookups, inserts and deletes, mostly
   // well formed; now and then a whole-space insert, a random port or opcode 3.
   // Most episodes end by deleting what they enabled, so the count returns to zero
   // and the next whole insert does a full sweep.
   task automatic run_episode();
      logic [PORT_W-1:0] pool [8];
      int pool_n;
      int steps;
      int r;
      logic [1:0] op;
      logic [PORT_W-1:0] port;
      logic whole;
      logic full;
      pool_n = $urandom_range(1, 8);
      foreach (pool[i]) pool[i] = PORT_W'($urandom);
      if ($urandom_range(0, 4) == 0)
         pool[0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
      if (enabled_total == 0 && $urandom_range(0, 5) == 0)
         issue(OP_INSERT, PORT_W'($urandom), 1'b1, 1'($urandom_range(0, 1)));
      steps = $urandom_range(4, 40);
      repeat (steps) begin
         r = $urandom_range(0, 99);
         port = ($urandom_range(0, 9) == 0) ? PORT_W'($urandom)
                                            : pool[$urandom_range(0, pool_n - 1)];
         whole = 1'b0;
         full = 1'($urandom_range(0, 1));
         if (r < 35) begin
            op = OP_LOOKUP;
            whole = ($urandom_range(0, 7) == 0);
         end else if (r < 70) begin
            op = OP_INSERT;
            whole = ($urandom_range(0, 19) == 0);
            enabled_list.push_back(port);
         end else if (r < 96) begin
            op = OP_DELETE;
            whole = 1'($urandom_range(0, 1));
            full = ($urandom_range(0, 4) != 0);
         end else begin
            op = OP_UNUSED;
            whole = 1'($urandom_range(0, 1));
         end
         issue(op, port, whole, full);
      end
      if ($urandom_range(0, 9) < 7) begin
         foreach (enabled_list[i])
            issue(OP_DELETE, enabled_list[i], 1'($urandom_range(0, 1)), 1'b1);
         enabled_list.delete();
      end
   endtask

   // Directed table. Rows marked typed carry an answer readable at a glance;
   // the rest are checked against the predictor.
   stim_row_type directed_rows [25] = '{
      // lookups right after reset: nothing enabled, answer covers the whole space
      '{OP_LOOKUP, 16'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 16'h0, 1'b0, 17'd0, 32'd0, 1'b0}},
      '{OP_LOOKUP, 16'hffff, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 16'h0, 1'b0, 17'd0, 32'd0, 1'b0}},
      // unused opcode: flags clear
      '{OP_UNUSED, 16'hffff, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 17'd0, 32'd0, 1'b0}},
      // delete without full rights: no change, no flush
      '{OP_DELETE, 16'h0005, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 17'd0, 32'd0, 1'b0}},
      // delete with full rights of a disabled port: flush only
      '{OP_DELETE, 16'h0005, 1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0, 1'b1, 17'd0, 32'd0, 1'b0}},
      // first enable, then the same port again
      '{OP_INSERT, 16'h0000, 1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 17'd1, 32'd1, 1'b0}},
      '{OP_INSERT, 16'h0000, 1'b0, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 16'h0, 1'b0, 17'd1, 32'd1, 1'b0}},
      '{OP_INSERT, 16'hffff, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h0000, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'hffff, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h1234, 1'b0, 1'b0, 1'b0, NO_ANS},
      // whole insert with ports partly enabled: single enable of the named port
      '{OP_INSERT, 16'h8000, 1'b1, 1'b0, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h8000, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_DELETE, 16'h0000, 1'b0, 1'b1, 1'b0, NO_ANS},
      '{OP_DELETE, 16'hffff, 1'b1, 1'b1, 1'b0, NO_ANS},
      '{OP_DELETE, 16'h8000, 1'b0, 1'b1, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h002a, 1'b0, 1'b0, 1'b0, NO_ANS},
      // whole insert with nothing enabled: full sweep into whole mode
      '{OP_INSERT, 16'h0000, 1'b1, 1'b0, 1'b0, NO_ANS},
      '{OP_INSERT, 16'h5555, 1'b1, 1'b0, 1'b0, NO_ANS},
      '{OP_INSERT, 16'h004d, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h0009, 1'b1, 1'b0, 1'b0, NO_ANS},
      '{OP_UNUSED, 16'haaaa, 1'b0, 1'b0, 1'b0, NO_ANS},
      '{OP_DELETE, 16'h0003, 1'b1, 1'b0, 1'b0, NO_ANS},
      // single-port delete in whole mode still sweeps everything off
      '{OP_DELETE, 16'h0003, 1'b0, 1'b1, 1'b0, NO_ANS},
      '{OP_LOOKUP, 16'h0003, 1'b0, 1'b0, 1'b0, NO_ANS}
   };

   initial begin : main_seq
      int episodes;
      int directed_n;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_LOOKUP;
      req_port        = '0;
      req_whole       = 1'b0;
      req_full_rights = 1'b0;
      port_off        = '1;
      enabled_total   = 0;
      revision        = '0;
      whole_mode      = 1'b0;
      sweeps          = 0;
      errors          = 0;
      sent            = 0;
      checked         = 0;
      cycle_count     = 0;
      burst_left      = 0;
      episodes        = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // the clearing pass after reset holds req_stall; send_request waits it out
      foreach (directed_rows[i])
         issue(directed_rows[i].op, directed_rows[i].port, directed_rows[i].whole,
               directed_rows[i].full, directed_rows[i].typed, directed_rows[i].ans);
      directed_n = sent;
      drain_results();

      while (sent < directed_n + RANDOM_ITEMS) begin
         run_episode();
         episodes++;
         // every twelfth episode, the sender holds off until the block has answered everything
         if (episodes % 12 == 5) drain_results();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests (%0d directed, %0d episodes), %0d whole-space sweeps,",
               sent, directed_n, episodes, sweeps);
      $display("%0d results checked, %0d mismatches, %0d cycles",
               checked, errors, cycle_count);
      if (errors == 0 && answers_due.size() == 0) begin
         $display("io_port_permission_bitmap_tb: done, clean");
      end else begin
         $display("io_port_permission_bitmap_tb: done, errors");
      end
      $finish;
   end

endmodule
